// ===== rtl/cdsp_pkg.sv =====
// Shared types and constants of the charger duty sweep and power loop block.
`timescale 1ns / 1ps

package cdsp_pkg;

  localparam int DUTY_W = 7;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam int PWR_W = 23;
  localparam int PWR_SHIFT = 38;
  localparam logic [28:0] PWR_RECIP = 29'h10624DD3;

  localparam logic [DUTY_W-1:0] DUTY_PING = 7'd10;
  localparam logic [DUTY_W-1:0] SWEEP_FIRST = 7'd20;
  localparam logic [DUTY_W-1:0] SWEEP_LAST = 7'd80;
  localparam logic [DUTY_W-1:0] SWEEP_STEP = 7'd10;
  localparam logic [DUTY_W-1:0] LOOP_MAX = 7'd90;
  localparam logic [DUTY_W-1:0] LOOP_MIN = 7'd10;
  localparam logic [DUTY_W-1:0] LOOP_STEP = 7'd2;
  localparam logic [DUTY_W-1:0] LOOP_RESET = 7'd20;
  localparam logic [DUTY_W-1:0] BEST_RESET = 7'd50;

  localparam logic [39:0] BAND_SCALE = 40'd100;
  localparam logic [39:0] BAND_LOW = 40'd90;
  localparam logic [39:0] BAND_HIGH = 40'd110;

  localparam logic [CFG_W-1:0] PRESENCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd500;
  localparam logic [CFG_W-1:0] DWELL_RESET = 16'd300;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PING = 3'd1,
    PH_IDENT = 3'd2,
    PH_SWEEP = 3'd3,
    PH_XFER = 3'd4
  } phase_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic [15:0] battery_mv;
    logic [15:0] current_ma;
    logic [31:0] measured_power_mw;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pwm_duty;
    logic [2:0] phase;
    logic [6:0] chosen_duty;
  } out_item_t;

  typedef struct packed {
    logic             operation;
    logic [31:0]      now_ms;
    logic [31:0]      measured_power_mw;
    logic [PWR_W-1:0] pwr_bucket;
    logic             below_band;
    logic             above_band;
  } front_item_t;

endpackage

// ===== rtl/cdsp_front.sv =====
// Measurement pipeline that computes sweep power and the transfer band flags.
`timescale 1ns / 1ps

module cdsp_front
  import cdsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        f_valid,
  input  logic        f_ready,
  output front_item_t f_item
);

  logic        a_valid;
  in_item_t    a_item;
  logic        b_valid;
  in_item_t    b_item;
  logic [31:0] b_product;
  logic        b_below;
  logic        b_above;
  logic        c_valid;
  front_item_t c_item;

  logic        a_ready;
  logic        b_ready;
  logic        c_ready;
  logic [31:0] product;
  logic [39:0] low_lhs;
  logic [39:0] low_rhs;
  logic [39:0] high_lhs;
  logic [39:0] high_rhs;
  logic [60:0] recip_prod;

  assign c_ready = !c_valid || f_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign product = {16'b0, a_item.battery_mv} * {16'b0, a_item.current_ma};
  assign low_lhs = ({8'b0, a_item.measured_power_mw} + 40'd1) * BAND_SCALE;
  assign low_rhs = {24'b0, a_item.battery_mv} * BAND_LOW;
  assign high_lhs = {8'b0, a_item.measured_power_mw} * BAND_SCALE;
  assign high_rhs = {24'b0, a_item.battery_mv} * BAND_HIGH;

  assign recip_prod = {29'b0, b_product} * {32'b0, PWR_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_item <= in_item;
    end
    if (b_ready && a_valid) begin
      b_item <= a_item;
      b_product <= product;
      b_below <= (low_lhs <= low_rhs);
      b_above <= (high_lhs > high_rhs);
    end
    if (c_ready && b_valid) begin
      c_item.operation <= b_item.operation;
      c_item.now_ms <= b_item.now_ms;
      c_item.measured_power_mw <= b_item.measured_power_mw;
      c_item.pwr_bucket <= recip_prod[PWR_SHIFT +: PWR_W];
      c_item.below_band <= b_below;
      c_item.above_band <= b_above;
    end
  end

  assign f_valid = c_valid;
  assign f_item = c_item;

endmodule

// ===== rtl/charger_duty_sweep_and_power_loop_top.sv =====
// Top level of the charger duty sweep and power loop controller.
`timescale 1ns / 1ps

// The block accepts one input transaction per clock cycle while out_stall does not hold
// the pipeline, and returns exactly one result transaction for each, in order. An input
// accepted into the input register moves on to the register after the 16x16 power
// product, then to the register after the divide-by-1000 reciprocal multiply, and then
// through the state update, which loads the output register. The state update is
// combinational, so consecutive items never wait on one another. Configuration writes
// are always ready; index 0 is the presence threshold, 1 the settle time, 2 the sweep
// dwell and 3 the loop period, and other indexes are ignored. Reset is synchronous.
module charger_duty_sweep_and_power_loop_top
  import cdsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] presence_threshold_mw;
  logic [CFG_W-1:0] settle_time_ms;
  logic [CFG_W-1:0] sweep_dwell_ms;
  logic [CFG_W-1:0] loop_period_ms;

  phase_t            phase;
  phase_t            phase_next;
  logic [DUTY_W-1:0] applied_duty;
  logic [DUTY_W-1:0] applied_duty_next;
  logic [DUTY_W-1:0] loop_duty;
  logic [DUTY_W-1:0] loop_duty_next;
  logic [DUTY_W-1:0] best_duty;
  logic [DUTY_W-1:0] best_duty_next;
  logic [DUTY_W-1:0] sweep_duty;
  logic [DUTY_W-1:0] sweep_duty_next;
  logic [PWR_W-1:0]  max_bucket;
  logic [PWR_W-1:0]  max_bucket_next;
  logic [31:0]       stage_stamp;
  logic [31:0]       stage_stamp_next;
  logic [31:0]       loop_stamp;
  logic [31:0]       loop_stamp_next;

  logic              front_ready;
  logic              f_valid;
  front_item_t       f_item;
  logic              out_ready;
  logic              fire;
  logic [31:0]       stage_elapsed;
  logic [31:0]       loop_elapsed;
  logic              settle_done;
  logic              dwell_done;
  logic              period_done;
  logic              present;
  logic              new_max;
  logic [DUTY_W-1:0] best_pick;

  cdsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (front_ready),
    .in_item  (in_item),
    .f_valid  (f_valid),
    .f_ready  (out_ready),
    .f_item   (f_item)
  );

  assign in_stall = !front_ready;
  assign out_ready = !out_valid || !out_stall;
  assign fire = f_valid && out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold_mw <= PRESENCE_RESET;
      settle_time_ms <= SETTLE_RESET;
      sweep_dwell_ms <= DWELL_RESET;
      loop_period_ms <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESENCE: presence_threshold_mw <= cfg_data;
        REG_SETTLE:   settle_time_ms <= cfg_data;
        REG_DWELL:    sweep_dwell_ms <= cfg_data;
        REG_PERIOD:   loop_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stage_elapsed = f_item.now_ms - stage_stamp;
  assign loop_elapsed = f_item.now_ms - loop_stamp;
  assign settle_done = stage_elapsed >= {16'b0, settle_time_ms};
  assign dwell_done = stage_elapsed >= {16'b0, sweep_dwell_ms};
  assign period_done = loop_elapsed >= {16'b0, loop_period_ms};
  assign present = f_item.measured_power_mw > {16'b0, presence_threshold_mw};
  assign new_max = f_item.pwr_bucket > max_bucket;
  assign best_pick = new_max ? sweep_duty : best_duty;

  always_comb begin
    phase_next = phase;
    applied_duty_next = applied_duty;
    loop_duty_next = loop_duty;
    best_duty_next = best_duty;
    sweep_duty_next = sweep_duty;
    max_bucket_next = max_bucket;
    stage_stamp_next = stage_stamp;
    loop_stamp_next = loop_stamp;
    if (f_item.operation == OP_START) begin
      phase_next = PH_PING;
      loop_duty_next = LOOP_RESET;
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_PING: begin
          applied_duty_next = DUTY_PING;
          stage_stamp_next = f_item.now_ms;
          phase_next = PH_IDENT;
        end
        PH_IDENT: begin
          if (settle_done) begin
            if (present) begin
              phase_next = PH_SWEEP;
              sweep_duty_next = SWEEP_FIRST;
              max_bucket_next = '0;
              best_duty_next = SWEEP_FIRST;
              applied_duty_next = SWEEP_FIRST;
              stage_stamp_next = f_item.now_ms;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_SWEEP: begin
          if (dwell_done) begin
            if (new_max) begin
              max_bucket_next = f_item.pwr_bucket;
            end
            best_duty_next = best_pick;
            if (sweep_duty >= SWEEP_LAST) begin
              loop_duty_next = best_pick;
              applied_duty_next = best_pick;
              phase_next = PH_XFER;
              loop_stamp_next = f_item.now_ms;
            end else begin
              sweep_duty_next = sweep_duty + SWEEP_STEP;
              applied_duty_next = sweep_duty + SWEEP_STEP;
              stage_stamp_next = f_item.now_ms;
            end
          end
        end
        PH_XFER: begin
          if (period_done) begin
            loop_stamp_next = f_item.now_ms;
            if (f_item.below_band && (loop_duty < LOOP_MAX)) begin
              loop_duty_next = loop_duty + LOOP_STEP;
              applied_duty_next = loop_duty + LOOP_STEP;
            end else if (f_item.above_band && (loop_duty > LOOP_MIN)) begin
              loop_duty_next = loop_duty - LOOP_STEP;
              applied_duty_next = loop_duty - LOOP_STEP;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      applied_duty <= '0;
      loop_duty <= LOOP_RESET;
      best_duty <= BEST_RESET;
      sweep_duty <= SWEEP_FIRST;
      max_bucket <= '0;
      stage_stamp <= '0;
      loop_stamp <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase <= phase_next;
        applied_duty <= applied_duty_next;
        loop_duty <= loop_duty_next;
        best_duty <= best_duty_next;
        sweep_duty <= sweep_duty_next;
        max_bucket <= max_bucket_next;
        stage_stamp <= stage_stamp_next;
        loop_stamp <= loop_stamp_next;
      end
      if (out_ready) begin
        out_valid <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.pwm_duty <= applied_duty_next;
      out_item.phase <= phase_next;
      out_item.chosen_duty <= best_duty_next;
    end
  end

  // Controller state moves only when a transaction passes into the output register.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(applied_duty) && $stable(loop_duty))
    else $error("controller state changed without a transaction");

  // The closed loop never drives the duty outside its limits.
  a_loop_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_XFER |-> (loop_duty >= LOOP_MIN) && (loop_duty <= LOOP_MAX))
    else $error("loop duty left its range during transfer");

  // The sweep only visits duties from the first to the last sweep step.
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SWEEP |-> (sweep_duty >= SWEEP_FIRST) && (sweep_duty <= SWEEP_LAST))
    else $error("sweep duty left its range");

  // The chosen duty is always one that a sweep can produce, or its reset value.
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (best_duty >= SWEEP_FIRST) && (best_duty <= SWEEP_LAST))
    else $error("chosen duty out of range");

endmodule
